>>> hdl/usb_config_descriptor_parser_assert.svh
// assertion macros for the configuration descriptor parser
// used by the top level only, no other dependencies
`ifndef USB_CONFIG_DESCRIPTOR_PARSER_ASSERT_SVH
`define USB_CONFIG_DESCRIPTOR_PARSER_ASSERT_SVH

// implication checked on every rising edge outside reset
`define UCDP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define UCDP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ucdp_pkg.sv
// shared types and constants for the configuration descriptor parser
// no dependencies
package ucdp_pkg;

	localparam int unsigned MaxInterfacesDef = 8;
	localparam int unsigned MaxEndpointsDef  = 16;

	localparam logic [7:0] TypeIface  = 8'h04;
	localparam logic [7:0] TypeEp     = 8'h05;
	localparam logic [7:0] TypeSsComp = 8'h30;

	localparam logic [10:0] MaxPacketMask = 11'h7FF;

	typedef enum logic [1:0] {
		KIND_IFACE   = 2'd0,
		KIND_EP      = 2'd1,
		KIND_COMP    = 2'd2,
		KIND_SUMMARY = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [3:0]  iface_slot;
		logic [3:0]  endpoint_slot;
		logic [7:0]  field_zero;
		logic [7:0]  field_one;
		logic [7:0]  field_two;
		logic [7:0]  field_three;
		logic [7:0]  field_four;
		logic [10:0] ep_max_size;
		logic        parse_status;
		logic        last_result;
	} out_item_t;

	// front-to-back queue entry: up to two records produced by one byte
	typedef struct packed {
		logic      two;
		out_item_t rec0;
		out_item_t rec1;
	} qent_t;

endpackage

>>> hdl/ucdp_front.sv
// front part: accepts bytes, walks the descriptor chain, builds records
// depends on ucdp_pkg
module ucdp_front #(
	parameter int unsigned MAX_INTERFACES = ucdp_pkg::MaxInterfacesDef,
	parameter int unsigned MAX_ENDPOINTS  = ucdp_pkg::MaxEndpointsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_go,
	input  ucdp_pkg::in_item_t in_item,
	output logic               ent_valid,
	output ucdp_pkg::qent_t    ent
);
	localparam int unsigned IW = $clog2(MAX_INTERFACES + 1);
	localparam int unsigned EW = $clog2(MAX_ENDPOINTS + 1);

	logic          halted_q;
	logic [7:0]    off_q, len_q, type_q;
	logic [3:0]    seen_q;
	logic [7:0]    cap_q [6];
	logic [IW-1:0] ift_q;
	logic          have_if_q;
	logic [EW-1:0] ept_q;
	logic          have_ep_q;
	logic [3:0]    ep_slot_q;
	logic [7:0]    cfg_q;

	logic [7:0] b;
	logic       lst, halt_now, fin;
	logic [7:0] len_eff, type_eff;
	logic [7:0] c [6];
	logic       do_if, do_ep, do_cp, if_full;
	ucdp_pkg::out_item_t rd, rs;
	logic [3:0] seen_n;
	logic       bad;

	always_comb begin
		b = in_item.data_byte;
		lst = in_item.last_byte;
		len_eff = (off_q == 8'd0) ? b : len_q;
		type_eff = (off_q == 8'd1) ? b : type_q;
		for (int i = 0; i < 6; i++) begin
			c[i] = (off_q == 8'(i + 2)) ? b : cap_q[i];
		end
		halt_now = !halted_q && off_q == 8'd0 && b == 8'd0;
		fin = !halted_q && !halt_now && ({1'b0, off_q} + 9'd1 >= {1'b0, len_eff});
		if_full = ift_q >= IW'(MAX_INTERFACES);
		do_if = fin && type_eff == ucdp_pkg::TypeIface && len_eff >= 8'd9;
		do_ep = fin && !do_if && have_if_q && type_eff == ucdp_pkg::TypeEp
			&& len_eff >= 8'd7 && ept_q < EW'(MAX_ENDPOINTS);
		do_cp = fin && !do_if && !(have_if_q && type_eff == ucdp_pkg::TypeEp
			&& len_eff >= 8'd7) && have_ep_q && type_eff == ucdp_pkg::TypeSsComp
			&& len_eff >= 8'd6;
		rd = '0;
		if (do_if && !if_full) begin
			rd.record_kind = ucdp_pkg::KIND_IFACE;
			rd.iface_slot = 4'(ift_q);
			rd.field_zero = c[0];
			rd.field_one = c[1];
			rd.field_two = c[3];
			rd.field_three = c[4];
			rd.field_four = c[5];
		end else if (do_ep) begin
			rd.record_kind = ucdp_pkg::KIND_EP;
			rd.iface_slot = 4'(ift_q - IW'(1));
			rd.endpoint_slot = 4'(ept_q);
			rd.field_zero = c[0];
			rd.field_one = c[1];
			rd.field_two = c[4];
			rd.ep_max_size = {c[3][2:0], c[2]} & ucdp_pkg::MaxPacketMask;
		end else if (do_cp) begin
			rd.record_kind = ucdp_pkg::KIND_COMP;
			rd.iface_slot = 4'(ift_q - IW'(1));
			rd.endpoint_slot = ep_slot_q;
			rd.field_zero = c[0];
		end
		seen_n = (seen_q == 4'd15) ? seen_q : seen_q + 4'd1;
		bad = seen_n < 4'd9;
		rs = '0;
		rs.record_kind = ucdp_pkg::KIND_SUMMARY;
		rs.iface_slot = bad ? 4'd0 : 4'(ift_q + IW'(do_if && !if_full));
		rs.field_zero = bad ? 8'd0 : ((seen_q == 4'd5) ? b : cfg_q);
		rs.parse_status = bad;
		rs.last_result = 1'b1;
	end

	always_comb begin
		logic has_rec;
		has_rec = (do_if && !if_full) || do_ep || do_cp;
		ent_valid = in_go && (has_rec || lst);
		ent = '0;
		if (has_rec && lst) begin
			ent.two = 1'b1;
			ent.rec0 = rd;
			ent.rec1 = rs;
		end else if (has_rec) begin
			ent.rec0 = rd;
			ent.rec0.last_result = 1'b1;
		end else begin
			ent.rec0 = rs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0; off_q <= '0; len_q <= '0; type_q <= '0; seen_q <= '0;
			ift_q <= '0; have_if_q <= 1'b0; ept_q <= '0; have_ep_q <= 1'b0;
			ep_slot_q <= '0; cfg_q <= '0;
		end else if (in_go) begin
			if (lst) begin
				halted_q <= 1'b0; off_q <= '0; len_q <= '0; type_q <= '0; seen_q <= '0;
				ift_q <= '0; have_if_q <= 1'b0; ept_q <= '0; have_ep_q <= 1'b0;
				ep_slot_q <= '0; cfg_q <= '0;
			end else begin
				seen_q <= seen_n;
				if (seen_q == 4'd5) cfg_q <= b;
				if (!halted_q) begin
					if (off_q == 8'd0) len_q <= b;
					if (off_q == 8'd1) type_q <= b;
					if (halt_now || (do_if && if_full)) halted_q <= 1'b1;
					if (fin) off_q <= '0;
					else if (!halt_now) off_q <= off_q + 8'd1;
					if (do_if && !if_full) begin
						ift_q <= ift_q + IW'(1);
						have_if_q <= 1'b1;
						ept_q <= '0;
						have_ep_q <= 1'b0;
					end else if (do_ep) begin
						ep_slot_q <= 4'(ept_q);
						have_ep_q <= 1'b1;
						ept_q <= ept_q + EW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_go && !halted_q) begin
			for (int i = 0; i < 6; i++) begin
				if (off_q == 8'(i + 2)) cap_q[i] <= b;
			end
		end
	end

endmodule

>>> hdl/ucdp_queue.sv
// two-entry queue between front and back parts
// depends on ucdp_pkg
module ucdp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  ucdp_pkg::qent_t wr_data,
	input  logic            rd,
	output logic            not_empty,
	output logic            full,
	output ucdp_pkg::qent_t rd_data
);
	ucdp_pkg::qent_t mem_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;

	assign not_empty = cnt_q != 2'd0;
	assign full = cnt_q == 2'd2;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

>>> hdl/ucdp_back.sv
// back part: unpacks queue entries into single record transfers
// depends on ucdp_pkg
module ucdp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_ne,
	input  ucdp_pkg::qent_t     q_data,
	output logic                q_rd,
	output logic                valid,
	input  logic                stall,
	output ucdp_pkg::out_item_t item
);
	logic sel_q;

	assign valid = q_ne;
	assign item = sel_q ? q_data.rec1 : q_data.rec0;
	assign q_rd = q_ne && !stall && (sel_q || !q_data.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (q_ne && !stall) begin
			sel_q <= !sel_q && q_data.two;
		end
	end

endmodule

>>> hdl/usb_config_descriptor_parser.sv
// top level of the usb configuration descriptor parser
// depends on ucdp_pkg, ucdp_front, ucdp_queue, ucdp_back and the assert header
//
// usage
// - in channel: one descriptor buffer byte per transfer, last_byte marks the end
// - out channel: interface, endpoint, companion and summary records
// - a byte causes up to two records; the last record of a byte has last_result
// - a record is written into the queue as its byte is taken and offered from the queue head
// - throughput: one byte per cycle while the out side keeps up; a byte that
//   makes two records needs two out transfers, set by the single out port
// - the front parses and pushes into a two-entry queue; in stall is raised
//   only when the queue is full, so bytes keep flowing while a record waits
// - out stall holds the current record steady; nothing is dropped
// - reset clears the parse state, but not the captured descriptor bytes, and empties the queue
// - after the last byte the parser rearms for a fresh buffer at once
`include "usb_config_descriptor_parser_assert.svh"

module usb_config_descriptor_parser #(
	parameter int unsigned MAX_INTERFACES = ucdp_pkg::MaxInterfacesDef,
	parameter int unsigned MAX_ENDPOINTS  = ucdp_pkg::MaxEndpointsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ucdp_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output ucdp_pkg::out_item_t out_item
);
	logic            in_go;
	logic            ent_valid;
	ucdp_pkg::qent_t ent;
	logic            q_ne, q_full, q_rd;
	ucdp_pkg::qent_t q_data;

	// stall whenever the queue cannot take a full entry
	assign in_stall = q_full;
	assign in_go = in_valid && !in_stall;

	ucdp_front #(
		.MAX_INTERFACES(MAX_INTERFACES),
		.MAX_ENDPOINTS (MAX_ENDPOINTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_go    (in_go),
		.in_item  (in_item),
		.ent_valid(ent_valid),
		.ent      (ent)
	);

	ucdp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (ent_valid),
		.wr_data  (ent),
		.rd       (q_rd),
		.not_empty(q_ne),
		.full     (q_full),
		.rd_data  (q_data)
	);

	ucdp_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.q_ne  (q_ne),
		.q_data(q_data),
		.q_rd  (q_rd),
		.valid (out_valid),
		.stall (out_stall),
		.item  (out_item)
	);

	`UCDP_ASSERT_IMPL(a_no_overflow, ent_valid, !q_full, "queue write while full")
	`UCDP_ASSERT_IMPL(a_summary_last, out_valid && out_item.record_kind == ucdp_pkg::KIND_SUMMARY,
		out_item.last_result, "summary record without last_result")
	`UCDP_ASSERT_NEXT(a_last_empty, in_go && in_item.last_byte, out_valid,
		"no record after last byte")

endmodule

>>> tb/usb_config_descriptor_parser_tb.sv
// testbench for the usb configuration descriptor parser
// drives descriptor buffers byte by byte and checks every record against a local predictor
// depends on ucdp_pkg and usb_config_descriptor_parser
`timescale 1ns / 100ps

module usb_config_descriptor_parser_tb;

	localparam int unsigned MaxIfaces = 8;
	localparam int unsigned MaxEps    = 16;
	localparam longint     CycleLimit = 200000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	ucdp_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_stall;
	ucdp_pkg::out_item_t out_item;

	usb_config_descriptor_parser u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predictor state, mirrors the parser walking the descriptor chain
	logic       p_halted;
	logic [7:0] p_offset;
	logic [7:0] p_length;
	logic [7:0] p_type;
	logic [3:0] p_seen;
	logic [7:0] p_bytes [6];
	logic [3:0] p_ifaces;
	logic       p_have_iface;
	logic [4:0] p_eps;
	logic       p_have_ep;
	logic [3:0] p_ep_slot;
	logic [7:0] p_cfg;

	ucdp_pkg::in_item_t  bytes_pending [$];
	ucdp_pkg::out_item_t records_expected [$];
	int        errors = 0;
	int        records_seen = 0;
	int        buffers_sent = 0;
	int        bytes_sent = 0;
	int        kind_count [4] = '{default: 0};
	longint    cycles = 0;

	task automatic clear_walk();
		p_halted = 1'b0;
		p_offset = '0;
		p_length = '0;
		p_type = '0;
		p_seen = '0;
		foreach (p_bytes[i])
			p_bytes[i] = '0;
		p_ifaces = '0;
		p_have_iface = 1'b0;
		p_eps = '0;
		p_have_ep = 1'b0;
		p_ep_slot = '0;
		p_cfg = '0;
	endtask

	// act on a descriptor whose final byte just arrived
	task automatic close_descriptor(inout int n);
		ucdp_pkg::out_item_t r;
		r = '0;
		if (p_type == ucdp_pkg::TypeIface && p_length >= 9) begin
			if (p_ifaces >= MaxIfaces) begin
				p_halted = 1'b1;
				return;
			end
			r.record_kind = ucdp_pkg::KIND_IFACE;
			r.iface_slot = p_ifaces;
			r.field_zero = p_bytes[0];
			r.field_one = p_bytes[1];
			r.field_two = p_bytes[3];
			r.field_three = p_bytes[4];
			r.field_four = p_bytes[5];
			p_ifaces++;
			p_have_iface = 1'b1;
			p_eps = '0;
			p_have_ep = 1'b0;
		end else if (p_have_iface && p_type == ucdp_pkg::TypeEp && p_length >= 7) begin
			if (p_eps >= MaxEps)
				return;
			r.record_kind = ucdp_pkg::KIND_EP;
			r.iface_slot = p_ifaces - 4'd1;
			r.endpoint_slot = p_eps[3:0];
			r.field_zero = p_bytes[0];
			r.field_one = p_bytes[1];
			r.field_two = p_bytes[4];
			r.ep_max_size = {p_bytes[3][2:0], p_bytes[2]} & ucdp_pkg::MaxPacketMask;
			p_ep_slot = p_eps[3:0];
			p_have_ep = 1'b1;
			p_eps++;
		end else if (p_have_ep && p_type == ucdp_pkg::TypeSsComp && p_length >= 6) begin
			r.record_kind = ucdp_pkg::KIND_COMP;
			r.iface_slot = p_ifaces - 4'd1;
			r.endpoint_slot = p_ep_slot;
			r.field_zero = p_bytes[0];
		end else begin
			return;
		end
		records_expected.push_back(r);
		n++;
	endtask

	task automatic predict_byte(input ucdp_pkg::in_item_t it);
		ucdp_pkg::out_item_t r;
		int n;
		n = 0;
		if (p_seen == 5)
			p_cfg = it.data_byte;
		if (!p_halted) begin
			if (p_offset == 0) begin
				p_length = it.data_byte;
				if (it.data_byte == 0)
					p_halted = 1'b1;
			end else if (p_offset == 1) begin
				p_type = it.data_byte;
			end else if (p_offset < 8) begin
				p_bytes[p_offset - 2] = it.data_byte;
			end
			if (!p_halted) begin
				if ({1'b0, p_offset} + 9'd1 >= {1'b0, p_length}) begin
					close_descriptor(n);
					p_offset = '0;
				end else begin
					p_offset++;
				end
			end
		end
		if (p_seen < 15)
			p_seen++;
		if (it.last_byte) begin
			r = '0;
			r.record_kind = ucdp_pkg::KIND_SUMMARY;
			r.parse_status = (p_seen < 9);
			r.iface_slot = r.parse_status ? 4'd0 : p_ifaces;
			r.field_zero = r.parse_status ? 8'd0 : p_cfg;
			records_expected.push_back(r);
			n++;
			clear_walk();
		end
		if (n > 0)
			records_expected[$].last_result = 1'b1;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("mismatch at record %0d: %s got %0h want %0h", records_seen, what, got, want);
	endtask

	// stimulus builders
	task automatic push_byte(input logic [7:0] b, input logic last);
		ucdp_pkg::in_item_t it;
		it.data_byte = b;
		it.last_byte = last;
		bytes_pending.push_back(it);
	endtask

	task automatic push_desc(input logic [7:0] len, input logic [7:0] kind, input int body);
		push_byte(len, 1'b0);
		if (body > 0)
			push_byte(kind, 1'b0);
		for (int i = 2; i < body; i++)
			push_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// a mostly well-formed buffer with random content and some noise
	task automatic push_buffer(input int mode);
		int ndesc;
		int len;
		int pick;
		push_desc(9, 8'h02, 9);
		if (mode == 1) begin
			// short buffer: keep only the first few bytes of the header
			repeat (9 - $urandom_range(1, 8))
				void'(bytes_pending.pop_back());
		end else begin
			ndesc = $urandom_range(0, 14);
			for (int d = 0; d < ndesc; d++) begin
				pick = $urandom_range(0, 19);
				if (pick < 4)
					push_desc(8'(9 + $urandom_range(0, 1)), ucdp_pkg::TypeIface,
						9 + $urandom_range(0, 1));
				else if (pick < 11)
					push_desc(8'(7 + $urandom_range(0, 1)), ucdp_pkg::TypeEp,
						7 + $urandom_range(0, 1));
				else if (pick < 15)
					push_desc(6, ucdp_pkg::TypeSsComp, 6);
				else if (pick < 17) begin
					len = $urandom_range(1, 10);
					push_desc(8'(len), 8'($urandom_range(0, 255)), len);
				end else if (pick == 17) begin
					len = $urandom_range(2, 8);
					push_desc(8'(len), pick[0] ? ucdp_pkg::TypeIface : ucdp_pkg::TypeEp, len);
				end else if (pick == 18 && $urandom_range(0, 3) == 0)
					push_byte(8'h00, 1'b0);
				else
					push_desc(9, ucdp_pkg::TypeIface, $urandom_range(2, 8));
			end
		end
		if (bytes_pending.size() == 0 || $urandom_range(0, 3) == 0)
			push_byte(8'($urandom_range(0, 255)), 1'b0);
		bytes_pending[$].last_byte = 1'b1;
		buffers_sent++;
	endtask

	// driver: idles a random number of cycles before each byte
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_byte(in_item);
				bytes_sent++;
			end
			if (in_valid && in_stall) begin
				// hold the stalled transfer
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (bytes_pending.size() > 0) begin
				in_valid <= 1'b1;
				in_item <= bytes_pending.pop_front();
				in_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: random stall per record, compares each accepted record
	int out_hold;
	always @(posedge clk or negedge arst_n) begin
		ucdp_pkg::out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				records_seen++;
				if (records_expected.size() == 0) begin
					report_mismatch("unexpected record", 64'(out_item), 64'(0));
				end else begin
					want = records_expected.pop_front();
					kind_count[want.record_kind]++;
					if (out_item.record_kind !== want.record_kind)
						report_mismatch("record_kind", 64'(out_item.record_kind),
							64'(want.record_kind));
					if (out_item.iface_slot !== want.iface_slot)
						report_mismatch("iface_slot", 64'(out_item.iface_slot),
							64'(want.iface_slot));
					if (out_item.endpoint_slot !== want.endpoint_slot)
						report_mismatch("endpoint_slot", 64'(out_item.endpoint_slot),
							64'(want.endpoint_slot));
					if (out_item.field_zero !== want.field_zero)
						report_mismatch("field_zero", 64'(out_item.field_zero),
							64'(want.field_zero));
					if (out_item.field_one !== want.field_one)
						report_mismatch("field_one", 64'(out_item.field_one),
							64'(want.field_one));
					if (out_item.field_two !== want.field_two)
						report_mismatch("field_two", 64'(out_item.field_two),
							64'(want.field_two));
					if (out_item.field_three !== want.field_three)
						report_mismatch("field_three", 64'(out_item.field_three),
							64'(want.field_three));
					if (out_item.field_four !== want.field_four)
						report_mismatch("field_four", 64'(out_item.field_four),
							64'(want.field_four));
					if (out_item.ep_max_size !== want.ep_max_size)
						report_mismatch("ep_max_size", 64'(out_item.ep_max_size),
							64'(want.ep_max_size));
					if (out_item.parse_status !== want.parse_status)
						report_mismatch("parse_status", 64'(out_item.parse_status),
							64'(want.parse_status));
					if (out_item.last_result !== want.last_result)
						report_mismatch("last_result", 64'(out_item.last_result),
							64'(want.last_result));
				end
			end
			// new stall length per transfer, long runs of zero too
			if (out_valid && !out_stall)
				out_hold <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
			else if (out_hold > 0)
				out_hold <= out_hold - 1;
			out_stall <= (out_hold > 1) || (out_valid && !out_stall && $urandom_range(0, 2) == 0);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("** usb_config_descriptor_parser: FAILED **");
			$finish;
		end
	end

	initial begin
		clear_walk();
		arst_n = 1'b0;

		// directed: one byte buffer, zero length halt, full interface + endpoint + companion
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		for (int i = 0; i < 8; i++)
			push_byte(i == 4 ? 8'hFF : 8'h00, 1'b0);
		push_byte(8'hAA, 1'b1);
		push_byte(9, 1'b0); push_byte(2, 1'b0); push_byte(8'hFF, 1'b0);
		push_byte(0, 1'b0); push_byte(1, 1'b0); push_byte(8'hFF, 1'b0);
		push_byte(0, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'hFA, 1'b0);
		push_byte(9, 1'b0); push_byte(ucdp_pkg::TypeIface, 1'b0); push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(7, 1'b0); push_byte(ucdp_pkg::TypeEp, 1'b0); push_byte(8'h81, 1'b0);
		push_byte(8'h03, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_desc(6, ucdp_pkg::TypeSsComp, 6);
		push_byte(8'h07, 1'b1); // truncated descriptor at the end
		buffers_sent = 3;

		// endpoint and interface limits: many endpoints, then more than eight interfaces
		push_desc(9, 8'h02, 9);
		push_desc(9, ucdp_pkg::TypeIface, 9);
		for (int e = 0; e < MaxEps + 2; e++)
			push_desc(7, ucdp_pkg::TypeEp, 7);
		push_desc(6, ucdp_pkg::TypeSsComp, 6);
		for (int k = 0; k < MaxIfaces + 2; k++)
			push_desc(9, ucdp_pkg::TypeIface, 9);
		push_desc(7, ucdp_pkg::TypeEp, 7);
		bytes_pending[$].last_byte = 1'b1;
		buffers_sent++;

		// random buffers
		while (bytes_pending.size() < 850)
			push_buffer($urandom_range(0, 9) == 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (bytes_pending.size() == 0 && !in_valid);
		wait (records_expected.size() == 0);
		repeat (20) @(posedge clk);

		$display("sent %0d bytes in %0d buffers, checked %0d records", bytes_sent,
			buffers_sent, records_seen);
		$display("records by kind: iface %0d, endpoint %0d, companion %0d, summary %0d",
			kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
		if (errors == 0) begin
			$display("** usb_config_descriptor_parser: PASSED **");
		end else begin
			$display("** usb_config_descriptor_parser: FAILED **");
		end
		$finish;
	end

endmodule
